@@ src/tprp_pkg.sv @@
// Package for the timed packet release pool.
// Holds sizes, action/status/writer codes and the shared structs.
// No dependencies.
package tprp_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_BYTES = 2048;
  localparam int DLY_W      = 32;
  localparam int CMP_W      = (DLY_W > 32) ? DLY_W : 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int OFF_W      = $clog2(SLOT_BYTES);
  localparam int ADDR_W     = SLOT_W + OFF_W;
  localparam int MEM_DEPTH  = SLOT_COUNT * SLOT_BYTES;
  localparam int LEN_W      = 12;
  localparam int RDY_W      = 6;

  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [2:0] ST_TAKEN  = 3'd0;
  localparam logic [2:0] ST_STORED = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_LONG   = 3'd3;
  localparam logic [2:0] ST_BYTE   = 3'd4;
  localparam logic [2:0] ST_NONE   = 3'd5;
  localparam logic [2:0] ST_TICK   = 3'd6;
  localparam logic [2:0] ST_QUERY  = 3'd7;

  localparam logic [1:0] WS_IDLE      = 2'd0;
  localparam logic [1:0] WS_STORE     = 2'd1;
  localparam logic [1:0] WS_DROP_FULL = 2'd2;
  localparam logic [1:0] WS_DROP_LONG = 2'd3;

  typedef struct packed {
    logic cap;
    logic st_do;
    logic scan_clr;
    logic scan_step;
    logic rd_start;
    logic rd_fin;
    logic out_load;
  } tprp_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       rd_active;
    logic       scan_last;
    logic       hit;
    logic       out_free;
  } tprp_sts_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       byte_out;
    logic             last;
    logic [LEN_W-1:0] len;
    logic [RDY_W-1:0] rdy;
    logic [31:0]      dly;
  } tprp_res_t;

endpackage

@@ src/timed_packet_release_pool_top.sv @@
// Top level of the timed packet release pool.
// Depends on tprp_pkg, tprp_ctrl and tprp_dp.
//
// Usage: items arrive on the in_ stream; in_tuser carries the action (store
// byte, read byte, tick, query) and in_tlast marks the last byte of a stored
// packet. Each item produces exactly one result transfer on the out_ stream,
// where out_tuser carries the status and out_tlast the last retrieved byte.
// One item is worked on at a time. A store is done in the dispatch step; a read
// inside a packet goes through an address step and a data step, since the read
// port of the packet memory is registered, and a read that starts a packet first
// scans the slots from slot 0 until one holds a ready packet that fits. Tick,
// query and a read that finds nothing ready walk all 32 slots one per cycle.
// Reset (synchronous, rst_n low) frees all slots and ends any write or read
// in progress. A stalled receiver holds the result in the output register;
// one further item may be worked on, and its result waits until the output
// register is free.
module timed_packet_release_pool_top
  import tprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // data_byte, delay, max_size, elapsed
  input  logic [1:0]  in_tuser,   // action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // byte_out, packet_length, ready_count, smallest_delay
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast
);

  tprp_cmd_t cmd;
  tprp_sts_t sts;

  tprp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tprp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ src/tprp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module tprp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tprp_ctrl.sv @@
// Controller state machine for the timed packet release pool.
// Depends on tprp_pkg; drives the datapath through tprp_cmd_t.
module tprp_ctrl
  import tprp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tprp_sts_t sts,
  output tprp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RSCAN = 3'd3;
  localparam logic [2:0] S_RADDR = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.act)
          ACT_STORE: begin
            cmd.st_do = 1'b1;
            state_nxt = S_OUT;
          end
          ACT_READ: begin
            if (sts.rd_active) begin
              state_nxt = S_RADDR;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_RSCAN;
            end
          end
          default: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_RSCAN: begin
        if (sts.hit) begin
          cmd.rd_start = 1'b1;
          state_nxt    = S_RADDR;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RADDR: state_nxt = S_RDATA;
      S_RDATA: begin
        cmd.rd_fin = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cap_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> state_r == S_DISP)
    else $error("capture did not lead to dispatch");
`endif

endmodule

@@ src/tprp_dp.sv @@
// Datapath of the timed packet release pool: slot tables, writer and reader
// state, slot scan, packet memory and output register.
// Depends on tprp_pkg and tprp_ram.
module tprp_dp
  import tprp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  tprp_cmd_t   cmd,
  output tprp_sts_t   sts
);

  logic [1:0]        it_act_r;
  logic [7:0]        it_byte_r;
  logic              it_last_r;
  logic [31:0]       it_delay_r;
  logic [LEN_W-1:0]  it_lim_r;
  logic [31:0]       it_el_r;

  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [DLY_W-1:0]      delay_r [SLOT_COUNT];
  logic [DLY_W-1:0]      delay_nxt [SLOT_COUNT];
  logic [LEN_W-1:0]      len_r [SLOT_COUNT];
  logic [LEN_W-1:0]      len_nxt [SLOT_COUNT];

  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [LEN_W-1:0]  wr_off_r, wr_off_nxt;
  logic [1:0]        wr_state_r, wr_state_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [LEN_W-1:0]  rd_off_r, rd_off_nxt;
  logic              rd_active_r, rd_active_nxt;
  logic [LEN_W-1:0]  rd_len_r, rd_len_nxt;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [RDY_W-1:0]  cnt_r, cnt_nxt;
  logic [DLY_W-1:0]  best_r, best_nxt;
  logic              any_r, any_nxt;

  tprp_res_t res_r, res_nxt, out_r;
  logic      out_valid_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_rdata;
  logic [ADDR_W-1:0] ram_raddr;

  logic [SLOT_W-1:0] free_idx;
  logic              any_free;
  logic              scan_last;
  logic              hit;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign scan_last = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign hit = used_r[idx_r] && (delay_r[idx_r] == '0) && (len_r[idx_r] <= it_lim_r);
  assign ram_raddr = {rd_slot_r, rd_off_r[OFF_W-1:0]};

  assign sts.act       = it_act_r;
  assign sts.rd_active = rd_active_r;
  assign sts.scan_last = scan_last;
  assign sts.hit       = hit;
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    logic [SLOT_W-1:0] s;
    logic [LEN_W:0]    off1;
    logic [DLY_W-1:0]  d;

    used_nxt      = used_r;
    delay_nxt     = delay_r;
    len_nxt       = len_r;
    wr_slot_nxt   = wr_slot_r;
    wr_off_nxt    = wr_off_r;
    wr_state_nxt  = wr_state_r;
    rd_slot_nxt   = rd_slot_r;
    rd_off_nxt    = rd_off_r;
    rd_active_nxt = rd_active_r;
    rd_len_nxt    = rd_len_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    any_nxt       = any_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = {wr_slot_r, wr_off_r[OFF_W-1:0]};
    s             = wr_slot_r;
    off1          = '0;
    d             = delay_r[idx_r];

    if (cmd.st_do) begin
      res_nxt = '0;
      if (wr_state_r == WS_DROP_FULL || wr_state_r == WS_DROP_LONG) begin
        res_nxt.status = {1'b0, wr_state_r};
        if (it_last_r) begin
          wr_state_nxt = WS_IDLE;
        end
      end else if (wr_state_r == WS_IDLE && !any_free) begin
        res_nxt.status = ST_FULL;
        wr_state_nxt   = it_last_r ? WS_IDLE : WS_DROP_FULL;
      end else begin
        if (wr_state_r == WS_IDLE) begin
          s              = free_idx;
          wr_slot_nxt    = free_idx;
          delay_nxt[s]   = DLY_W'(it_delay_r);
          len_nxt[s]     = '0;
          wr_state_nxt   = WS_STORE;
          off1           = (LEN_W + 1)'(1);
          ram_waddr      = {free_idx, {OFF_W{1'b0}}};
          ram_we         = 1'b1;
        end else if (32'(wr_off_r) >= 32'(SLOT_BYTES)) begin
          delay_nxt[s]   = '0;
          wr_off_nxt     = '0;
          wr_state_nxt   = it_last_r ? WS_IDLE : WS_DROP_LONG;
          res_nxt.status = ST_LONG;
        end else begin
          off1   = {1'b0, wr_off_r} + (LEN_W + 1)'(1);
          ram_we = 1'b1;
        end
        if (ram_we) begin
          wr_off_nxt  = off1[LEN_W-1:0];
          res_nxt.len = off1[LEN_W-1:0];
          if (it_last_r) begin
            len_nxt[s]     = off1[LEN_W-1:0];
            used_nxt[s]    = 1'b1;
            wr_state_nxt   = WS_IDLE;
            wr_off_nxt     = '0;
            res_nxt.status = ST_STORED;
          end else begin
            res_nxt.status = ST_TAKEN;
          end
        end
      end
    end

    if (cmd.scan_clr) begin
      idx_nxt  = '0;
      cnt_nxt  = '0;
      best_nxt = '0;
      any_nxt  = 1'b0;
    end

    if (cmd.scan_step) begin
      idx_nxt = idx_r + SLOT_W'(1);
      case (it_act_r)
        ACT_TICK: begin
          if (used_r[idx_r]) begin
            if (CMP_W'(d) <= CMP_W'(it_el_r)) begin
              delay_nxt[idx_r] = '0;
              cnt_nxt          = cnt_r + RDY_W'(1);
            end else begin
              delay_nxt[idx_r] = d - DLY_W'(it_el_r);
            end
          end
          if (scan_last) begin
            res_nxt        = '0;
            res_nxt.status = ST_TICK;
            res_nxt.rdy    = cnt_nxt;
          end
        end
        ACT_QUERY: begin
          if (used_r[idx_r] && (!any_r || d < best_r)) begin
            best_nxt = d;
            any_nxt  = 1'b1;
          end
          if (scan_last) begin
            res_nxt        = '0;
            res_nxt.status = ST_QUERY;
            res_nxt.dly    = 32'(best_nxt);
          end
        end
        default: begin
          if (scan_last) begin
            res_nxt        = '0;
            res_nxt.status = ST_NONE;
          end
        end
      endcase
    end

    if (cmd.rd_start) begin
      rd_slot_nxt   = idx_r;
      rd_off_nxt    = '0;
      rd_active_nxt = 1'b1;
      rd_len_nxt    = len_r[idx_r];
    end

    if (cmd.rd_fin) begin
      off1             = {1'b0, rd_off_r} + (LEN_W + 1)'(1);
      res_nxt          = '0;
      res_nxt.status   = ST_BYTE;
      res_nxt.byte_out = ram_rdata;
      res_nxt.len      = rd_len_r;
      rd_off_nxt       = off1[LEN_W-1:0];
      if (off1 >= {1'b0, rd_len_r}) begin
        res_nxt.last         = 1'b1;
        used_nxt[rd_slot_r]  = 1'b0;
        delay_nxt[rd_slot_r] = '0;
        len_nxt[rd_slot_r]   = '0;
        rd_active_nxt        = 1'b0;
        rd_off_nxt           = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      wr_slot_r   <= '0;
      wr_off_r    <= '0;
      wr_state_r  <= WS_IDLE;
      rd_slot_r   <= '0;
      rd_off_r    <= '0;
      rd_active_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        delay_r[i] <= '0;
        len_r[i]   <= '0;
      end
    end else begin
      used_r      <= used_nxt;
      delay_r     <= delay_nxt;
      len_r       <= len_nxt;
      wr_slot_r   <= wr_slot_nxt;
      wr_off_r    <= wr_off_nxt;
      wr_state_r  <= wr_state_nxt;
      rd_slot_r   <= rd_slot_nxt;
      rd_off_r    <= rd_off_nxt;
      rd_active_r <= rd_active_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_len_r <= rd_len_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    any_r    <= any_nxt;
    res_r    <= res_nxt;
    if (cmd.cap) begin
      it_act_r   <= in_tuser;
      it_byte_r  <= in_tdata[7:0];
      it_last_r  <= in_tlast;
      it_delay_r <= in_tdata[39:8];
      it_lim_r   <= in_tdata[51:40];
      it_el_r    <= in_tdata[83:52];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  tprp_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(it_byte_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {6'b0, out_r.dly, out_r.rdy, out_r.len, out_r.byte_out};

`ifndef SYNTHESIS
  a_read_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    rd_active_r |-> used_r[rd_slot_r])
    else $error("active read on a free slot");
  a_write_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_state_r == WS_STORE) |-> !used_r[wr_slot_r])
    else $error("partial packet in a used slot");
  a_fin_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_fin |-> rd_active_r)
    else $error("byte delivered without an active read");
`endif

endmodule
